[src/qnl_pkg.sv]
`default_nettype none

package qnl_pkg;

    localparam int COMP_W  = 16;
    localparam int FRAC_W  = 14;
    localparam int BLEND_W = 16;
    localparam int LANES   = 4;
    localparam int PROD_W  = 2 * COMP_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int MAG_W   = 31;
    localparam int SHIFT_W = 5;
    localparam int SQR_W   = 2 * MAG_W;
    localparam int SQ_W    = 64;
    localparam int ROOT_W  = 32;
    localparam int REM_W   = ROOT_W + 4;
    localparam int Q_W     = FRAC_W + 1;
    localparam int NUM_W   = MAG_W + FRAC_W + 1;

    localparam logic [BLEND_W-1:0] ONE_Q15 = BLEND_W'(32768);

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        mag_t [LANES-1:0] mag;
        logic [LANES-1:0] neg;
        logic             zero;
    } side_t;

    typedef struct packed {
        logic en;
        logic vld;
    } pipe_ctl_t;

endpackage

`default_nettype wire

[src/qnl_in_if.sv]
`default_nettype none

interface qnl_in_if;
    logic                          valid;
    logic                          ready;
    qnl_pkg::comp_t                first_x;
    qnl_pkg::comp_t                first_y;
    qnl_pkg::comp_t                first_z;
    qnl_pkg::comp_t                first_w;
    qnl_pkg::comp_t                second_x;
    qnl_pkg::comp_t                second_y;
    qnl_pkg::comp_t                second_z;
    qnl_pkg::comp_t                second_w;
    logic [qnl_pkg::BLEND_W-1:0]   blend;

    modport source (
        output valid, first_x, first_y, first_z, first_w,
        output second_x, second_y, second_z, second_w, blend,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, first_w,
        input  second_x, second_y, second_z, second_w, blend,
        output ready
    );
endinterface

`default_nettype wire

[src/qnl_out_if.sv]
`default_nettype none

interface qnl_out_if;
    logic           valid;
    logic           ready;
    qnl_pkg::comp_t out_x;
    qnl_pkg::comp_t out_y;
    qnl_pkg::comp_t out_z;
    qnl_pkg::comp_t out_w;
    logic           zero_length;

    modport source (
        output valid, out_x, out_y, out_z, out_w, zero_length,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, out_w, zero_length,
        output ready
    );
endinterface

`default_nettype wire

[src/qnl_norm.sv]
`default_nettype none

module qnl_norm (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  qnl_pkg::pipe_ctl_t                          ctl,
    input  logic [qnl_pkg::SQ_W-1:0]                    sumsq,
    input  qnl_pkg::side_t                              side,
    output logic                                        vld,
    output qnl_pkg::comp_t [qnl_pkg::LANES-1:0]         res,
    output logic                                        zero
);
    import qnl_pkg::*;

    // square root, one result bit per stage
    logic [ROOT_W-1:0] sq_vld_reg;
    logic [REM_W-1:0]  sq_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] sq_root_reg [ROOT_W];
    logic [SQ_W-1:0]   sq_n_reg    [ROOT_W];
    side_t             sq_side_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SQ_W-1:0]   n_in;
        side_t             side_in;
        logic              vld_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = sumsq;
            assign side_in = side;
            assign vld_in  = ctl.vld;
        end
        else begin : g_next
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign n_in    = sq_n_reg[k-1];
            assign side_in = sq_side_reg[k-1];
            assign vld_in  = sq_vld_reg[k-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], n_in[SQ_W-1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            else if (ctl.en)
            begin
                sq_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                sq_rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                sq_root_reg[k] <= {root_in[ROOT_W-2:0], ge};
                sq_n_reg[k]    <= n_in << 2;
                sq_side_reg[k] <= side_in;
            end
        end
    end

    // divider set-up: rounded numerator split into head and feed bits
    logic                               pr_vld_reg;
    logic [LANES-1:0][ROOT_W-1:0]       pr_rem_reg;
    logic [LANES-1:0][Q_W-1:0]          pr_low_reg;
    logic [ROOT_W-1:0]                  pr_den_reg;
    logic [LANES-1:0]                   pr_neg_reg;
    logic                               pr_zero_reg;
    logic [LANES-1:0][NUM_W-1:0]        pr_num;
    logic [ROOT_W-1:0]                  len;

    assign len = sq_root_reg[ROOT_W-1];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            pr_num[i] = {1'b0, sq_side_reg[ROOT_W-1].mag[i], FRAC_W'(0)}
                      + NUM_W'(len >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_vld_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            pr_vld_reg <= sq_vld_reg[ROOT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                pr_rem_reg[i] <= ROOT_W'(pr_num[i][NUM_W-1:Q_W]);
                pr_low_reg[i] <= pr_num[i][Q_W-1:0];
            end
            pr_den_reg  <= len;
            pr_neg_reg  <= sq_side_reg[ROOT_W-1].neg;
            pr_zero_reg <= sq_side_reg[ROOT_W-1].zero;
        end
    end

    // restoring division, one quotient bit per stage, four lanes
    logic [Q_W-1:0]                dv_vld_reg;
    logic [LANES-1:0][ROOT_W-1:0]  dv_rem_reg  [Q_W];
    logic [LANES-1:0][Q_W-1:0]     dv_low_reg  [Q_W];
    logic [LANES-1:0][Q_W-1:0]     dv_q_reg    [Q_W];
    logic [ROOT_W-1:0]             dv_den_reg  [Q_W];
    logic [LANES-1:0]              dv_neg_reg  [Q_W];
    logic [Q_W-1:0]                dv_zero_reg;

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        logic [LANES-1:0][ROOT_W-1:0] rem_in;
        logic [LANES-1:0][Q_W-1:0]    low_in;
        logic [LANES-1:0][Q_W-1:0]    q_in;
        logic [ROOT_W-1:0]            den_in;
        logic [LANES-1:0]             neg_in;
        logic                         zero_in;
        logic                         vld_in;
        logic [LANES-1:0][ROOT_W:0]   r_sh;
        logic [LANES-1:0]             ge;
        logic [LANES-1:0][ROOT_W-1:0] rem_next;

        if (j == 0) begin : g_first
            assign rem_in  = pr_rem_reg;
            assign low_in  = pr_low_reg;
            assign q_in    = '0;
            assign den_in  = pr_den_reg;
            assign neg_in  = pr_neg_reg;
            assign zero_in = pr_zero_reg;
            assign vld_in  = pr_vld_reg;
        end
        else begin : g_next
            assign rem_in  = dv_rem_reg[j-1];
            assign low_in  = dv_low_reg[j-1];
            assign q_in    = dv_q_reg[j-1];
            assign den_in  = dv_den_reg[j-1];
            assign neg_in  = dv_neg_reg[j-1];
            assign zero_in = dv_zero_reg[j-1];
            assign vld_in  = dv_vld_reg[j-1];
        end

        always_comb
        begin
            for (int i = 0; i < LANES; i++)
            begin
                r_sh[i]     = {rem_in[i], low_in[i][Q_W-1]};
                ge[i]       = (r_sh[i] >= {1'b0, den_in});
                rem_next[i] = ge[i] ? ROOT_W'(r_sh[i] - {1'b0, den_in})
                                    : ROOT_W'(r_sh[i]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[j] <= 1'b0;
            end
            else if (ctl.en)
            begin
                dv_vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    dv_rem_reg[j][i] <= rem_next[i];
                    dv_low_reg[j][i] <= low_in[i] << 1;
                    dv_q_reg[j][i]   <= {q_in[i][Q_W-2:0], ge[i]};
                end
                dv_den_reg[j]  <= den_in;
                dv_neg_reg[j]  <= neg_in;
                dv_zero_reg[j] <= zero_in;
            end
        end
    end

    // output word register
    logic                          out_vld_reg;
    comp_t [LANES-1:0]             out_res_reg;
    logic                          out_zero_reg;
    comp_t [LANES-1:0]             out_res_next;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (dv_zero_reg[Q_W-1])
            begin
                out_res_next[i] = '0;
            end
            else if (dv_neg_reg[Q_W-1][i])
            begin
                out_res_next[i] = -comp_t'({1'b0, dv_q_reg[Q_W-1][i]});
            end
            else
            begin
                out_res_next[i] = comp_t'({1'b0, dv_q_reg[Q_W-1][i]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            out_vld_reg <= dv_vld_reg[Q_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            out_res_reg  <= out_res_next;
            out_zero_reg <= dv_zero_reg[Q_W-1];
        end
    end

    assign vld  = out_vld_reg;
    assign res  = out_res_reg;
    assign zero = out_zero_reg;

`ifndef SYNTHESIS
    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld_reg[ROOT_W-1] && !sq_side_reg[ROOT_W-1].zero
        |-> sq_root_reg[ROOT_W-1][ROOT_W-1:ROOT_W-2] != 2'b00)
        else $error("root below 2^30 for non-zero word");
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[Q_W-1] && !dv_zero_reg[Q_W-1]
        |-> dv_q_reg[Q_W-1][0] <= Q_W'(1 << FRAC_W))
        else $error("quotient above one");
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_zero_reg |-> out_res_reg == '0)
        else $error("zero length word with non-zero components");
`endif

endmodule

`default_nettype wire

[src/quaternion_nlerp_top.sv]
// quaternion nlerp, shortest path
// in_ch carries two quaternions (signed q1.14 components) and a blend factor
// (unsigned q1.15, values above 1.0 taken as 1.0); out_ch carries the
// normalised blend in signed q1.14 and a zero_length flag, one output word
// for every input word, in order.
// from input acceptance to output valid a word passes ten front
// stages (dot product, sign flip, blend, block scaling, sum of squares),
// 32 square root stages at one root bit each, one divider set-up stage,
// 15 divider stages at one quotient bit each, and the output register.
// throughput is one word per cycle while out_ch.ready does not stall the pipeline; every stage can hold a word.
// the whole pipeline advances together; when out_ch.ready is low with a
// word waiting, every stage holds and in_ch.ready drops, nothing is lost
// or repeated. bubbles travel as invalid stages.
// reset clears all valid bits; the block holds no other state.
// a blend of zero length gives zero components and zero_length set.
`default_nettype none

module quaternion_nlerp_top (
    input  logic       clk,
    input  logic       rst_n,
    qnl_in_if.sink     in_ch,
    qnl_out_if.source  out_ch
);
    import qnl_pkg::*;

    localparam int FRONT = 10;

    logic              en;
    logic              norm_vld;
    logic [FRONT:1]    vld_reg;
    pipe_ctl_t         norm_ctl;
    comp_t [LANES-1:0] norm_res;
    logic              norm_zero;

    assign en          = !norm_vld || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[FRONT-1:1], in_ch.valid};
        end
    end

    // stage 1: capture and clamp
    comp_t [LANES-1:0]  a_in, b_in;
    logic [BLEND_W-1:0] f_clamp;
    comp_t [LANES-1:0]  a1_reg, b1_reg;
    logic [BLEND_W-1:0] f1_reg, g1_reg;

    assign a_in    = {in_ch.first_w, in_ch.first_z, in_ch.first_y, in_ch.first_x};
    assign b_in    = {in_ch.second_w, in_ch.second_z, in_ch.second_y, in_ch.second_x};
    assign f_clamp = (in_ch.blend > ONE_Q15) ? ONE_Q15 : in_ch.blend;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= a_in;
            b1_reg <= b_in;
            f1_reg <= f_clamp;
            g1_reg <= ONE_Q15 - f_clamp;
        end
    end

    // stage 2: dot product terms
    logic signed [PROD_W-1:0] p2_reg [LANES];
    comp_t [LANES-1:0]        a2_reg, b2_reg;
    logic [BLEND_W-1:0]       f2_reg, g2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                p2_reg[i] <= a1_reg[i] * b1_reg[i];
            end
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            f2_reg <= f1_reg;
            g2_reg <= g1_reg;
        end
    end

    // stage 3: dot sign and shortest path flip
    logic signed [DOT_W-1:0]    dot;
    logic                       flip;
    logic signed [COMP_W:0]     bb3_reg [LANES];
    comp_t [LANES-1:0]          a3_reg;
    logic [BLEND_W-1:0]         f3_reg, g3_reg;

    always_comb
    begin
        dot = '0;
        for (int i = 0; i < LANES; i++)
        begin
            dot = dot + DOT_W'(p2_reg[i]);
        end
        flip = dot[DOT_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                bb3_reg[i] <= flip ? -(COMP_W+1)'(b2_reg[i]) : (COMP_W+1)'(b2_reg[i]);
            end
            a3_reg <= a2_reg;
            f3_reg <= f2_reg;
            g3_reg <= g2_reg;
        end
    end

    // stage 4: blend products
    logic signed [DOT_W-1:0] ga4_reg [LANES];
    logic signed [DOT_W-1:0] fb4_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                ga4_reg[i] <= $signed({1'b0, g3_reg}) * a3_reg[i];
                fb4_reg[i] <= $signed({1'b0, f3_reg}) * bb3_reg[i];
            end
        end
    end

    // stage 5: blend sum, sign and magnitude
    logic signed [DOT_W-1:0] c5;
    logic [DOT_W-1:0]        abs5;
    mag_t [LANES-1:0]        mag5_reg;
    logic [LANES-1:0]        neg5_reg;

    function automatic logic [DOT_W-1:0] abs_of(input logic signed [DOT_W-1:0] v);
        logic [DOT_W-1:0] r;
        r = v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                mag5_reg[i] <= MAG_W'(abs_of(ga4_reg[i] + fb4_reg[i]));
                neg5_reg[i] <= (ga4_reg[i] + fb4_reg[i]) < 0;
            end
        end
    end

    assign c5   = ga4_reg[0] + fb4_reg[0];
    assign abs5 = abs_of(c5);

    // stage 6: largest magnitude
    mag_t             big01, big23;
    mag_t             big6_reg;
    mag_t [LANES-1:0] mag6_reg;
    logic [LANES-1:0] neg6_reg;

    assign big01 = (mag5_reg[0] > mag5_reg[1]) ? mag5_reg[0] : mag5_reg[1];
    assign big23 = (mag5_reg[2] > mag5_reg[3]) ? mag5_reg[2] : mag5_reg[3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big6_reg <= (big01 > big23) ? big01 : big23;
            mag6_reg <= mag5_reg;
            neg6_reg <= neg5_reg;
        end
    end

    // stage 7: leading zero count
    logic [SHIFT_W-1:0] lz;
    logic [SHIFT_W-1:0] lz7_reg;
    logic               zero7_reg;
    mag_t [LANES-1:0]   mag7_reg;
    logic [LANES-1:0]   neg7_reg;

    always_comb
    begin
        lz = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (big6_reg[i])
            begin
                lz = SHIFT_W'(MAG_W - 1 - i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lz7_reg   <= lz;
            zero7_reg <= (big6_reg == '0);
            mag7_reg  <= mag6_reg;
            neg7_reg  <= neg6_reg;
        end
    end

    // stage 8: block scaling
    side_t side8_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                side8_reg.mag[i] <= mag7_reg[i] << lz7_reg;
            end
            side8_reg.neg  <= neg7_reg;
            side8_reg.zero <= zero7_reg;
        end
    end

    // stage 9: squares
    logic [SQR_W-1:0] sq9_reg [LANES];
    side_t            side9_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                sq9_reg[i] <= side8_reg.mag[i] * side8_reg.mag[i];
            end
            side9_reg <= side8_reg;
        end
    end

    // stage 10: sum of squares
    logic [SQ_W-1:0] sum10_reg;
    side_t           side10_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum10_reg <= SQ_W'(sq9_reg[0]) + SQ_W'(sq9_reg[1])
                       + SQ_W'(sq9_reg[2]) + SQ_W'(sq9_reg[3]);
            side10_reg <= side9_reg;
        end
    end

    assign norm_ctl.en  = en;
    assign norm_ctl.vld = vld_reg[FRONT];

    qnl_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (norm_ctl),
        .sumsq (sum10_reg),
        .side  (side10_reg),
        .vld   (norm_vld),
        .res   (norm_res),
        .zero  (norm_zero)
    );

    assign out_ch.valid       = norm_vld;
    assign out_ch.out_x       = norm_res[0];
    assign out_ch.out_y       = norm_res[1];
    assign out_ch.out_z       = norm_res[2];
    assign out_ch.out_w       = norm_res[3];
    assign out_ch.zero_length = norm_zero;

`ifndef SYNTHESIS
    a_scaled_top: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[8] && !side8_reg.zero
        |-> (side8_reg.mag[0][MAG_W-1] || side8_reg.mag[1][MAG_W-1]
             || side8_reg.mag[2][MAG_W-1] || side8_reg.mag[3][MAG_W-1]))
        else $error("block scaling left largest magnitude low");
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> abs5 <= DOT_W'(1 << (2 * FRAC_W + 2)))
        else $error("blend magnitude out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg) && $stable(sum10_reg))
        else $error("pipeline moved during stall");
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.zero_length
        |-> out_ch.out_x <= comp_t'(1 << FRAC_W) && out_ch.out_x >= -comp_t'(1 << FRAC_W))
        else $error("component above unit length");
`endif

endmodule

`default_nettype wire
